[rtl/sksp_pkg.sv]
// Shared types and constants for the sub-pixel kernel shift and placement block.
// No dependencies; every other file of the block but sksp_ram imports this package.
package sksp_pkg;

   // Default kernel width limit and fixed limits of the block
   localparam int MaxKernelCols = 256;
   localparam int MaxImageDim   = 4096;
   localparam int KernelRowsCap = 4096;

   // Field widths
   localparam int SampleWidth  = 16;
   localparam int CoordWidth   = 12;
   localparam int PosWidth     = 15;   // signed image position, place plus offset
   localparam int WeightWidth  = 33;   // Q1.32, gx*gy reaches 2^32
   localparam int ProductWidth = 49;
   localparam int RoundBit     = 31;
   localparam int ValueLsb     = 32;

   // Queue between front and back end
   localparam int QueueDepth = 4;

   // Register port
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic [2:0] {
      RegKernelCols,
      RegKernelRows,
      RegPlaceX,
      RegPlaceY,
      RegShiftX,
      RegShiftY,
      RegImageCols,
      RegImageRows
   } reg_index_type;

   // Output pixels one sample can produce, in emission order
   typedef enum logic [1:0] {
      PixMain,
      PixRight,
      PixBottom,
      PixCorner
   } pixel_kind_type;

   typedef struct packed {
      logic        [8:0]  kernel_cols;
      logic        [12:0] kernel_rows;
      logic signed [12:0] place_x;
      logic signed [12:0] place_y;
      logic        [15:0] shift_x;
      logic        [15:0] shift_y;
      logic        [12:0] image_cols;
      logic        [12:0] image_rows;
   } cfg_type;

   // One classified sample: neighbours, candidate positions and surviving pixels
   typedef struct packed {
      logic [SampleWidth-1:0] cur;
      logic [SampleWidth-1:0] left;
      logic [SampleWidth-1:0] up;
      logic [SampleWidth-1:0] upper_left;
      logic [CoordWidth-1:0]  x_near;
      logic [CoordWidth-1:0]  x_far;
      logic [CoordWidth-1:0]  y_near;
      logic [CoordWidth-1:0]  y_far;
      logic [3:0]             mask;
   } job_type;

endpackage

[rtl/sksp_if.sv]
// Valid/ready channel interfaces for kernel samples in and placed pixels out.
// Depends on sksp_pkg for the payload widths.
interface sksp_req_if import sksp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SampleWidth-1:0] kernel_sample;

   modport source (output valid, output kernel_sample, input ready);
   modport sink   (input valid, input kernel_sample, output ready);
endinterface

interface sksp_rsp_if import sksp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CoordWidth-1:0]  out_x;
   logic [CoordWidth-1:0]  out_y;
   logic [SampleWidth-1:0] out_value;
   logic                   run_end;

   modport source (output valid, output out_x, output out_y, output out_value,
                   output run_end, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_value,
                   input run_end, output ready);
endinterface

[rtl/sksp_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module sksp_ram #(
   parameter  int Width     = 16,
   parameter  int Depth     = 256,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Read returns the old word when the same address is written in the same cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sksp_front.sv]
// Front end: accepts samples, tracks kernel position, fetches neighbours and
// classifies which output pixels land in the image. Uses sksp_pkg, sksp_if, sksp_ram.
module sksp_front import sksp_pkg::*; #(
   parameter int MAX_KERNEL_COLS = MaxKernelCols
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        restart,
   sksp_req_if.sink    req,
   output logic        push_valid,
   input  logic        push_ready,
   output job_type     push_job
);

   localparam int ColWidth   = $clog2(MAX_KERNEL_COLS);
   localparam int WidthBits  = $clog2(MAX_KERNEL_COLS + 1);

   logic [ColWidth-1:0]    col_ff, col_in;
   logic [11:0]            row_ff, row_in;
   logic [WidthBits-1:0]   kw;
   logic [12:0]            kh;
   logic [12:0]            img_cols, img_rows;
   logic                   last_col, last_row, accept;

   logic                   a_valid_ff, a_valid_in;
   logic [SampleWidth-1:0] a_cur_ff;
   logic [ColWidth-1:0]    a_col_ff;
   logic [11:0]            a_row_ff;
   logic                   a_last_col_ff, a_last_row_ff;
   logic                   a_advance;

   logic [SampleWidth-1:0] left_ff, upper_left_ff;
   logic [SampleWidth-1:0] ram_rd_data;
   logic [SampleWidth-1:0] up_sample, left_sample, ul_sample;
   logic [PosWidth-1:0]    x_near, x_far, y_near, y_far;
   logic                   in_x_near, in_x_far, in_y_near, in_y_far, copy_mode;
   logic [3:0]             mask;

   function automatic logic in_range(logic [PosWidth-1:0] p, logic [12:0] lim);
      return !p[PosWidth-1] && (p < PosWidth'(lim));
   endfunction

   // Effective kernel and image sizes
   always_comb begin
      if (cfg.kernel_cols == '0) begin
         kw = WidthBits'(1);
      end else if (32'(cfg.kernel_cols) > 32'(MAX_KERNEL_COLS)) begin
         kw = WidthBits'(MAX_KERNEL_COLS);
      end else begin
         kw = WidthBits'(cfg.kernel_cols);
      end
      if (cfg.kernel_rows == '0) begin
         kh = 13'd1;
      end else if (cfg.kernel_rows > 13'(KernelRowsCap)) begin
         kh = 13'(KernelRowsCap);
      end else begin
         kh = cfg.kernel_rows;
      end
      img_cols = (cfg.image_cols > 13'(MaxImageDim)) ? 13'(MaxImageDim) : cfg.image_cols;
      img_rows = (cfg.image_rows > 13'(MaxImageDim)) ? 13'(MaxImageDim) : cfg.image_rows;
   end

   assign accept   = req.valid && req.ready;
   assign last_col = (WidthBits'(col_ff) + WidthBits'(1)) == kw;
   assign last_row = (13'(row_ff) + 13'd1) == kh;

   // Advance the raster position; any register write restarts the kernel
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? 12'd0 : row_ff + 12'd1;
         end else begin
            col_in = col_ff + ColWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Row store: read the sample above and overwrite it with the new one
   sksp_ram #(
      .Width (SampleWidth),
      .Depth (MAX_KERNEL_COLS)
   ) u_row_above (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req.kernel_sample),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // Acceptance stage
   always_comb begin
      a_valid_in = a_valid_ff;
      if (accept) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cur_ff      <= req.kernel_sample;
         a_col_ff      <= col_ff;
         a_row_ff      <= row_ff;
         a_last_col_ff <= last_col;
         a_last_row_ff <= last_row;
      end
      if (a_advance) begin
         left_ff       <= a_cur_ff;
         upper_left_ff <= up_sample;
      end
   end

   // Neighbours; samples outside the kernel count as zero
   always_comb begin
      up_sample   = (a_row_ff != '0) ? ram_rd_data : '0;
      left_sample = (a_col_ff != '0) ? left_ff : '0;
      ul_sample   = (a_col_ff != '0 && a_row_ff != '0) ? upper_left_ff : '0;
   end

   // Image positions and clipping
   always_comb begin
      x_near    = PosWidth'(cfg.place_x) + PosWidth'(a_col_ff);
      x_far     = PosWidth'(cfg.place_x) + PosWidth'(kw);
      y_near    = PosWidth'(cfg.place_y) + PosWidth'(a_row_ff);
      y_far     = PosWidth'(cfg.place_y) + PosWidth'(kh);
      in_x_near = in_range(x_near, img_cols);
      in_x_far  = in_range(x_far, img_cols);
      in_y_near = in_range(y_near, img_rows);
      in_y_far  = in_range(y_far, img_rows);
      copy_mode = (cfg.shift_x == '0) && (cfg.shift_y == '0) && !kw[0] && !kh[0];

      mask            = '0;
      mask[PixMain]   = in_x_near && in_y_near;
      mask[PixRight]  = !copy_mode && a_last_col_ff && in_x_far && in_y_near;
      mask[PixBottom] = !copy_mode && a_last_row_ff && in_x_near && in_y_far;
      mask[PixCorner] = !copy_mode && a_last_col_ff && a_last_row_ff && in_x_far && in_y_far;
   end

   // Hand over to the queue; a sample with nothing to emit is dropped here
   always_comb begin
      push_job.cur        = a_cur_ff;
      push_job.left       = left_sample;
      push_job.up         = up_sample;
      push_job.upper_left = ul_sample;
      push_job.x_near     = x_near[CoordWidth-1:0];
      push_job.x_far      = x_far[CoordWidth-1:0];
      push_job.y_near     = y_near[CoordWidth-1:0];
      push_job.y_far      = y_far[CoordWidth-1:0];
      push_job.mask       = mask;
   end

   assign push_valid = a_valid_ff && (mask != '0);
   assign a_advance  = a_valid_ff && (push_ready || (mask == '0));
   assign req.ready  = !a_valid_ff || a_advance;

endmodule

[rtl/sksp_queue.sv]
// Short register queue of classified samples between front and back end.
// Uses sksp_pkg for the entry type and depth (a power of two).
module sksp_queue import sksp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   job_type               slots_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = count_ff != CountWidth'(QueueDepth);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointers wrap naturally
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/sksp_back.sv]
// Back end: expands each queued sample into its output pixels, one per cycle while
// unstalled, blending them in multiply, add, round stages. Uses sksp_pkg, sksp_if.
module sksp_back import sksp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  job_type     pop_job,
   sksp_rsp_if.source  rsp
);

   logic [16:0]             fx, fy, gx, gy;
   logic [WeightWidth-1:0]  w_ul_ff, w_l_ff, w_u_ff, w_c_ff;

   logic                    en;
   job_type                 jb_ff;
   logic                    jb_valid_ff, jb_valid_in;
   logic [3:0]              mask_ff, mask_next, pick_bit;
   pixel_kind_type          kind;
   logic                    take, load;

   logic [SampleWidth-1:0]  op_ul, op_l, op_u, op_c;
   logic [CoordWidth-1:0]   sel_x, sel_y;

   logic                    m_valid_ff, s_valid_ff, o_valid_ff;
   logic [ProductWidth-1:0] m_p0_ff, m_p1_ff, m_p2_ff, m_p3_ff;
   logic [ProductWidth-1:0] s_a_ff, s_b_ff;
   logic [ProductWidth-1:0] total;
   logic [16:0]             rounded;
   logic [CoordWidth-1:0]   m_x_ff, m_y_ff, s_x_ff, s_y_ff, o_x_ff, o_y_ff;
   logic                    m_end_ff, s_end_ff, o_end_ff;
   logic [SampleWidth-1:0]  o_value_ff;

   // Bilinear area weights from the fractions; they sum to 2^32
   always_comb begin
      fx = {1'b0, cfg.shift_x};
      fy = {1'b0, cfg.shift_y};
      gx = 17'h10000 - fx;
      gy = 17'h10000 - fy;
   end

   always_ff @(posedge clock) begin
      w_ul_ff <= WeightWidth'(fx) * WeightWidth'(fy);
      w_l_ff  <= WeightWidth'(fx) * WeightWidth'(gy);
      w_u_ff  <= WeightWidth'(gx) * WeightWidth'(fy);
      w_c_ff  <= WeightWidth'(gx) * WeightWidth'(gy);
   end

   // Whole back end holds while the output register is blocked
   assign en = !o_valid_ff || rsp.ready;

   // Pick the next surviving pixel of the current sample
   always_comb begin
      if (mask_ff[PixMain]) begin
         kind = PixMain;
      end else if (mask_ff[PixRight]) begin
         kind = PixRight;
      end else if (mask_ff[PixBottom]) begin
         kind = PixBottom;
      end else begin
         kind = PixCorner;
      end
      pick_bit  = 4'b0001 << kind;
      mask_next = mask_ff & ~pick_bit;

      op_ul = '0;
      op_l  = '0;
      op_u  = '0;
      op_c  = '0;
      sel_x = jb_ff.x_near;
      sel_y = jb_ff.y_near;
      case (kind)
         PixMain: begin
            op_ul = jb_ff.upper_left;
            op_l  = jb_ff.left;
            op_u  = jb_ff.up;
            op_c  = jb_ff.cur;
         end
         PixRight: begin
            op_ul = jb_ff.up;
            op_l  = jb_ff.cur;
            sel_x = jb_ff.x_far;
         end
         PixBottom: begin
            op_ul = jb_ff.left;
            op_u  = jb_ff.cur;
            sel_y = jb_ff.y_far;
         end
         PixCorner: begin
            op_ul = jb_ff.cur;
            sel_x = jb_ff.x_far;
            sel_y = jb_ff.y_far;
         end
         default: begin
            op_ul = '0;
         end
      endcase
   end

   assign take      = en && jb_valid_ff;
   assign load      = en && (!jb_valid_ff || (mask_next == '0));
   assign pop_ready = load;

   always_comb begin
      jb_valid_in = jb_valid_ff;
      if (load) begin
         jb_valid_in = pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jb_valid_ff <= 1'b0;
      end else begin
         jb_valid_ff <= jb_valid_in;
      end
   end

   // Load a new sample or retire the pixel just issued
   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         jb_ff   <= pop_job;
         mask_ff <= pop_job.mask;
      end else if (take) begin
         mask_ff <= mask_next;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= take;
         s_valid_ff <= m_valid_ff;
         o_valid_ff <= s_valid_ff;
      end
   end

   // Round half up and saturate
   always_comb begin
      total   = s_a_ff + s_b_ff + (ProductWidth'(1) << RoundBit);
      rounded = total[ValueLsb+16:ValueLsb];
   end

   // Multiply, pair sums, final sum
   always_ff @(posedge clock) begin
      if (en) begin
         m_p0_ff    <= ProductWidth'(op_ul) * ProductWidth'(w_ul_ff);
         m_p1_ff    <= ProductWidth'(op_l) * ProductWidth'(w_l_ff);
         m_p2_ff    <= ProductWidth'(op_u) * ProductWidth'(w_u_ff);
         m_p3_ff    <= ProductWidth'(op_c) * ProductWidth'(w_c_ff);
         m_x_ff     <= sel_x;
         m_y_ff     <= sel_y;
         m_end_ff   <= mask_next == '0;

         s_a_ff     <= m_p0_ff + m_p1_ff;
         s_b_ff     <= m_p2_ff + m_p3_ff;
         s_x_ff     <= m_x_ff;
         s_y_ff     <= m_y_ff;
         s_end_ff   <= m_end_ff;

         o_value_ff <= rounded[16] ? 16'hFFFF : rounded[15:0];
         o_x_ff     <= s_x_ff;
         o_y_ff     <= s_y_ff;
         o_end_ff   <= s_end_ff;
      end
   end

   assign rsp.valid     = o_valid_ff;
   assign rsp.out_x     = o_x_ff;
   assign rsp.out_y     = o_y_ff;
   assign rsp.out_value = o_value_ff;
   assign rsp.run_end   = o_end_ff;

endmodule

[rtl/subpixel_kernel_shift_place.sv]
// Sub-pixel kernel shift and placement, top level with register port.
// Path: acceptance register, queue, sample register, multiply, sum and output registers.
// Throughput: one sample per cycle while the queue has room; the blend pipeline issues one
// pixel per cycle while the output is free, so a last-column or last-row sample holds the
// back end for extra pixels; the 4-entry queue absorbs a row end; the last row runs slower.
// Reset: synchronous; registers to their defaults, kernel position to origin, queue empty.
module subpixel_kernel_shift_place import sksp_pkg::*; #(
   parameter int MAX_KERNEL_COLS = MaxKernelCols
) (
   input  logic                    clock,
   input  logic                    reset,
   sksp_req_if.sink                req_chan,
   sksp_rsp_if.source              rsp_chan,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   cfg_type        cfg_ff, cfg_in;
   reg_index_type  reg_index;
   logic           csr_write;
   logic           push_valid, push_ready, pop_valid, pop_ready;
   job_type        push_job, pop_job;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CsrAddrWidth-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            RegKernelCols: cfg_in.kernel_cols = pwdata[8:0];
            RegKernelRows: cfg_in.kernel_rows = pwdata[12:0];
            RegPlaceX:     cfg_in.place_x     = pwdata[12:0];
            RegPlaceY:     cfg_in.place_y     = pwdata[12:0];
            RegShiftX:     cfg_in.shift_x     = pwdata[15:0];
            RegShiftY:     cfg_in.shift_y     = pwdata[15:0];
            RegImageCols:  cfg_in.image_cols  = pwdata[12:0];
            RegImageRows:  cfg_in.image_rows  = pwdata[12:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_cols <= 9'd1;
         cfg_ff.kernel_rows <= 13'd1;
         cfg_ff.place_x     <= '0;
         cfg_ff.place_y     <= '0;
         cfg_ff.shift_x     <= '0;
         cfg_ff.shift_y     <= '0;
         cfg_ff.image_cols  <= 13'd4096;
         cfg_ff.image_rows  <= 13'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      case (reg_index)
         RegKernelCols: prdata = {23'd0, cfg_ff.kernel_cols};
         RegKernelRows: prdata = {19'd0, cfg_ff.kernel_rows};
         RegPlaceX:     prdata = {19'd0, cfg_ff.place_x};
         RegPlaceY:     prdata = {19'd0, cfg_ff.place_y};
         RegShiftX:     prdata = {16'd0, cfg_ff.shift_x};
         RegShiftY:     prdata = {16'd0, cfg_ff.shift_y};
         RegImageCols:  prdata = {19'd0, cfg_ff.image_cols};
         RegImageRows:  prdata = {19'd0, cfg_ff.image_rows};
         default:       prdata = '0;
      endcase
   end

   sksp_front #(
      .MAX_KERNEL_COLS (MAX_KERNEL_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .restart    (csr_write),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   sksp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   sksp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp       (rsp_chan)
   );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for subpixel_kernel_shift_place: streams kernel samples through the block,
// predicts every placed pixel and checks each result transaction field by field.
// Depends on sksp_pkg and the sksp_req_if / sksp_rsp_if channel interfaces.
module tb_top;
   import sksp_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int SettleGap   = 12;
   localparam int LongHoldOff = 150;

   typedef struct packed {
      logic [CoordWidth-1:0]  x;
      logic [CoordWidth-1:0]  y;
      logic [SampleWidth-1:0] value;
      logic                   run_end;
   } placed_pixel_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   sksp_req_if req_if ();
   sksp_rsp_if rsp_if ();

   subpixel_kernel_shift_place dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shifter state as the testbench sees it
   cfg_type                model_cfg = '{kernel_cols: 9'd1, kernel_rows: 13'd1,
                                         image_cols: 13'd4096, image_rows: 13'd4096,
                                         default: '0};
   int                     col_pos = 0;
   int                     row_pos = 0;
   logic [SampleWidth-1:0] left_sample = '0;
   logic [SampleWidth-1:0] upper_left = '0;
   logic [SampleWidth-1:0] row_above [MaxKernelCols];

   logic [SampleWidth-1:0] pending_samples [$];
   placed_pixel_type       expected_pixels [$];
   int                     mismatch_count = 0;
   int                     cycle_count = 0;
   int                     drv_gap = 0;
   int                     rsp_gap = 0;
   bit                     idle_on = 1'b0;
   bit                     hold_request = 1'b0;
   logic                   long_hold = 1'b0;

   task automatic report_mismatch(string what);
      $display("t=%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic int clamp_size(int v, int cap);
      return (v < 1) ? 1 : ((v > cap) ? cap : v);
   endfunction

   // Bilinear area blend of four neighbours, rounded half up and saturated
   function automatic logic [SampleWidth-1:0] area_blend(logic [SampleWidth-1:0] ul,
                                                          logic [SampleWidth-1:0] l,
                                                          logic [SampleWidth-1:0] u,
                                                          logic [SampleWidth-1:0] cur);
      logic [63:0] fx, fy, gx, gy, acc, rounded;
      fx = 64'(model_cfg.shift_x);
      fy = 64'(model_cfg.shift_y);
      gx = 64'd65536 - fx;
      gy = 64'd65536 - fy;
      acc = 64'(ul) * (fx * fy) + 64'(l) * (fx * gy) + 64'(u) * (gx * fy)
          + 64'(cur) * (gx * gy);
      rounded = (acc + 64'h8000_0000) >> 32;
      return (rounded > 64'd65535) ? 16'hFFFF : rounded[SampleWidth-1:0];
   endfunction

   // Drop pixels that fall outside the image, keep the rest
   function automatic void place_pixel(ref placed_pixel_type burst[$], input int i,
                                       input int j, input logic [SampleWidth-1:0] v);
      int               x, y, ic, ir;
      placed_pixel_type px;
      x  = int'($signed(model_cfg.place_x)) + i;
      y  = int'($signed(model_cfg.place_y)) + j;
      ic = (model_cfg.image_cols > MaxImageDim) ? MaxImageDim : int'(model_cfg.image_cols);
      ir = (model_cfg.image_rows > MaxImageDim) ? MaxImageDim : int'(model_cfg.image_rows);
      if (x < 0 || y < 0 || x >= ic || y >= ir) return;
      px.x       = x[CoordWidth-1:0];
      px.y       = y[CoordWidth-1:0];
      px.value   = v;
      px.run_end = 1'b0;
      burst.push_back(px);
   endfunction

   // Work out the pixels one accepted sample produces and advance the kernel position
   function automatic void predict_sample(logic [SampleWidth-1:0] cur);
      int                     kw, kh, c, r;
      logic [SampleWidth-1:0] up, left, ul;
      bit                     copy_mode, last_col, last_row;
      placed_pixel_type       burst [$];
      kw = clamp_size(model_cfg.kernel_cols, MaxKernelCols);
      kh = clamp_size(model_cfg.kernel_rows, KernelRowsCap);
      c = col_pos;
      r = row_pos;
      last_col  = (c == kw - 1);
      last_row  = (r == kh - 1);
      copy_mode = model_cfg.shift_x == 0 && model_cfg.shift_y == 0
                  && kw % 2 == 0 && kh % 2 == 0;
      up   = (r > 0) ? row_above[c] : '0;
      left = (c > 0) ? left_sample : '0;
      ul   = (c > 0 && r > 0) ? upper_left : '0;
      if (copy_mode) begin
         place_pixel(burst, c, r, cur);
      end else begin
         place_pixel(burst, c, r, area_blend(ul, left, up, cur));
         if (last_col) place_pixel(burst, kw, r, area_blend(up, cur, '0, '0));
         if (last_row) place_pixel(burst, c, kh, area_blend(left, '0, cur, '0));
         if (last_col && last_row) place_pixel(burst, kw, kh, area_blend(cur, '0, '0, '0));
      end
      if (burst.size() > 0) burst[burst.size() - 1].run_end = 1'b1;
      foreach (burst[k]) expected_pixels.push_back(burst[k]);
      upper_left   = up;
      left_sample  = cur;
      row_above[c] = cur;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // Sample driver: offer queued samples, predict on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         drv_gap      <= 0;
      end else begin
         if (req_if.valid && req_if.ready) predict_sample(req_if.kernel_sample);
         if (!req_if.valid || req_if.ready) begin
            if (drv_gap > 0) begin
               req_if.valid <= 1'b0;
               drv_gap      <= drv_gap - 1;
            end else if (pending_samples.size() > 0) begin
               req_if.valid         <= 1'b1;
               req_if.kernel_sample <= pending_samples.pop_front();
               drv_gap              <= idle_on ? $urandom_range(0, 5) : 0;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Pixel monitor: check each result transaction against the oldest expectation
   always @(posedge clock) begin : pixel_monitor
      placed_pixel_type want;
      int               gap;
      gap = rsp_gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected pixel x=%0d y=%0d value=%h",
                                         rsp_if.out_x, rsp_if.out_y, rsp_if.out_value));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_if.out_x !== want.x)
                  report_mismatch($sformatf("out_x %0d, want %0d", rsp_if.out_x, want.x));
               if (rsp_if.out_y !== want.y)
                  report_mismatch($sformatf("out_y %0d, want %0d", rsp_if.out_y, want.y));
               if (rsp_if.out_value !== want.value)
                  report_mismatch($sformatf("out_value %h at (%0d,%0d), want %h",
                                            rsp_if.out_value, want.x, want.y, want.value));
               if (rsp_if.run_end !== want.run_end)
                  report_mismatch($sformatf("run_end %b at (%0d,%0d), want %b",
                                            rsp_if.run_end, want.x, want.y, want.run_end));
            end
            gap = idle_on ? $urandom_range(0, 5) : 0;
         end else if (gap > 0) begin
            gap--;
         end
         rsp_if.ready <= (gap == 0) && !long_hold;
      end
      rsp_gap = gap;
   end

   // Long receiver hold-off, counted here while the sender keeps offering samples
   initial begin : receiver_hold
      wait (hold_request);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LongHoldOff) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Register write over the APB-style port; mirror it in the predictor
   task automatic csr_write(reg_index_type idx, logic [CsrDataWidth-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         RegKernelCols: model_cfg.kernel_cols = value[8:0];
         RegKernelRows: model_cfg.kernel_rows = value[12:0];
         RegPlaceX:     model_cfg.place_x     = value[12:0];
         RegPlaceY:     model_cfg.place_y     = value[12:0];
         RegShiftX:     model_cfg.shift_x     = value[15:0];
         RegShiftY:     model_cfg.shift_y     = value[15:0];
         RegImageCols:  model_cfg.image_cols  = value[12:0];
         RegImageRows:  model_cfg.image_rows  = value[12:0];
         default: ;
      endcase
      col_pos = 0;
      row_pos = 0;
   endtask

   // Wait until every sample is taken and every predicted pixel has arrived
   task automatic drain();
      while (pending_samples.size() != 0 || req_if.valid || expected_pixels.size() != 0)
         @(negedge clock);
   endtask

   // Reconfigure once the block is idle; clipped samples may still be in flight
   task automatic load_setup(int cols, int rows, int px, int py, int sx, int sy,
                             int icols, int irows);
      drain();
      repeat (SettleGap) @(posedge clock);
      csr_write(RegKernelCols, cols);
      csr_write(RegKernelRows, rows);
      csr_write(RegPlaceX, px);
      csr_write(RegPlaceY, py);
      csr_write(RegShiftX, sx);
      csr_write(RegShiftY, sy);
      csr_write(RegImageCols, icols);
      csr_write(RegImageRows, irows);
      @(negedge clock);
   endtask

   function automatic logic [SampleWidth-1:0] draw_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return SampleWidth'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic int pick_fraction();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 65535;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Random settings: mostly small kernels over a small image, now and then extremes
   task automatic random_setup(output int kw, output int kh);
      int cols, rows, px, py, sx, sy, icols, irows;
      if ($urandom_range(0, 3) == 0) begin
         // even sizes with no shift take the direct-copy path
         cols = 2 * $urandom_range(1, 4);
         rows = 2 * $urandom_range(1, 3);
         sx = 0;
         sy = 0;
      end else begin
         cols = $urandom_range(0, 10);
         rows = $urandom_range(0, 5);
         sx = pick_fraction();
         sy = pick_fraction();
      end
      px = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                       : int'($urandom_range(0, 12)) - 6;
      py = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                       : int'($urandom_range(0, 12)) - 6;
      icols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 20);
      irows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 20);
      load_setup(cols, rows, px, py, sx, sy, icols, irows);
      kw = clamp_size(cols, MaxKernelCols);
      kh = clamp_size(rows, KernelRowsCap);
   endtask

   initial begin : stimulus
      int kw, kh, count, random_items;
      req_if.valid         = 1'b0;
      req_if.kernel_sample = '0;
      rsp_if.ready         = 1'b0;
      foreach (row_above[k]) row_above[k] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Settings after reset: 1x1 kernel, four pixels per sample, no idling
      pending_samples.push_back(16'h0000);
      pending_samples.push_back(16'hFFFF);
      pending_samples.push_back(16'h8000);
      pending_samples.push_back(16'h7FFF);

      // Half-pixel shift on full-scale samples
      load_setup(2, 2, 0, 0, 16'h8000, 16'h8000, 4096, 4096);
      repeat (4) pending_samples.push_back(16'hFFFF);

      // Direct copy: even sizes, no shift
      idle_on = 1'b1;
      load_setup(2, 2, 3, 5, 0, 0, 4096, 4096);
      repeat (4) pending_samples.push_back(draw_sample());

      // Largest fractions, odd width, bottom border clipped by the image
      load_setup(3, 2, -1, 0, 65535, 65535, 8, 2);
      repeat (6) pending_samples.push_back(draw_sample());

      // Zero kernel sizes act as one; oversize image saturates at the right edge
      load_setup(0, 0, 4095, -1, 1, 65535, 8191, 8191);
      repeat (2) pending_samples.push_back(draw_sample());

      // Zero-sized image emits nothing
      load_setup(1, 1, -4096, -4096, 12345, 54321, 0, 4096);
      repeat (2) pending_samples.push_back(draw_sample());

      // Oversize width saturates: the start of the top row of the widest kernel
      load_setup(511, 0, -3, 2, pick_fraction(), pick_fraction(), 300, 4096);
      repeat (20) pending_samples.push_back(draw_sample());

      // Oversize height saturates; only the first row lands in the image corner
      load_setup(3, 8191, 4093, 4095, pick_fraction(), pick_fraction(), 4096, 4096);
      repeat (15) pending_samples.push_back(draw_sample());

      // Back-pressure: receiver holds off while samples keep coming, then a full pause
      load_setup(4, 4, 0, 0, pick_fraction(), pick_fraction(), 4096, 4096);
      hold_request = 1'b1;
      repeat (30) pending_samples.push_back(draw_sample());
      drain();
      repeat (12) pending_samples.push_back(draw_sample());

      // Random settings, mostly whole kernels, some cut short
      random_items = 0;
      while (random_items < 30) begin
         random_setup(kw, kh);
         count = kw * kh * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, kw * kh);
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (count) pending_samples.push_back(draw_sample());
         random_items += count;
      end

      drain();
      repeat (SettleGap) @(posedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
